@@ hdl/msr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msr_pkg: shared types and constants of the multi-servo slew ramp
// Channel count, command codes, reset values and the per-channel state record.
// ----------------------------------------------------------------------------
package msr_pkg;

  localparam int unsigned CHANNELS = 8;
  localparam int unsigned CH_W     = $clog2(CHANNELS);

  localparam logic [7:0]  POS_RESET  = 8'd45;
  localparam logic [7:0]  LOW_RESET  = 8'd45;
  localparam logic [7:0]  HIGH_RESET = 8'd135;
  localparam logic [7:0]  STEP_RESET = 8'd20;
  localparam logic [15:0] HOLD_RESET = 16'd300;

  // Configuration register indexes.
  localparam logic CFG_STEP_PERIOD = 1'b0;
  localparam logic CFG_HOLD        = 1'b1;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_SET_DIR = 2'd1,
    CMD_ADJUST  = 2'd2,
    CMD_LOAD    = 2'd3
  } cmd_e;

  // One accepted input item.
  typedef struct packed {
    cmd_e            cmd;
    logic [CH_W-1:0] channel;
    logic            direction;
    logic [7:0]      delta;
    logic [7:0]      low_limit_in;
    logic [7:0]      high_limit_in;
    logic [15:0]     now_ms;
  } item_t;

  // All state held for one servo channel.
  typedef struct packed {
    logic [7:0]  pos;
    logic [7:0]  prev_pos;
    logic [15:0] last_step;
    logic [15:0] last_move;
    logic        dir;
    logic        attached;
    logic [7:0]  low;
    logic [7:0]  high;
  } chan_t;

endpackage
`default_nettype wire

@@ hdl/msr_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msr_step: per-item channel update
// Applies one command to the selected channel's state record.
// ----------------------------------------------------------------------------
module msr_step (
  input  msr_pkg::item_t item_i,
  input  msr_pkg::chan_t chan_i,
  input  logic [7:0]     step_period_i,
  input  logic [15:0]    hold_i,
  output msr_pkg::chan_t chan_o,
  output logic           moved_o
);

  logic [15:0] since_step;
  logic [15:0] since_move;
  logic        due;
  logic [7:0]  target;
  logic [7:0]  stepped;
  logic        changed;
  logic        at_end;

  assign since_step = item_i.now_ms - chan_i.last_step;
  assign since_move = item_i.now_ms - chan_i.last_move;
  assign due        = since_step >= {8'd0, step_period_i};
  assign target     = chan_i.dir ? chan_i.low : chan_i.high;

  always_comb begin
    if (chan_i.pos < target) begin
      stepped = chan_i.pos + 8'd1;
    end else if (chan_i.pos > target) begin
      stepped = chan_i.pos - 8'd1;
    end else begin
      stepped = chan_i.pos;
    end
  end

  assign changed = stepped != chan_i.prev_pos;
  assign at_end  = (stepped == chan_i.high) || (stepped == chan_i.low);

  always_comb begin
    chan_o  = chan_i;
    moved_o = 1'b0;
    unique case (item_i.cmd)
      msr_pkg::CMD_TICK: begin
        if (due) begin
          chan_o.last_step = item_i.now_ms;
          chan_o.pos       = stepped;
          if (changed) begin
            // A move restarts the hold time, so no detach can follow it here.
            chan_o.prev_pos  = stepped;
            chan_o.attached  = 1'b1;
            chan_o.last_move = item_i.now_ms;
            moved_o          = 1'b1;
          end else if (at_end && (since_move > hold_i)) begin
            chan_o.attached = 1'b0;
          end
        end
      end
      msr_pkg::CMD_SET_DIR: begin
        chan_o.dir = item_i.direction;
      end
      msr_pkg::CMD_ADJUST: begin
        if (chan_i.dir) begin
          chan_o.low = chan_i.low + item_i.delta;
        end else begin
          chan_o.high = chan_i.high + item_i.delta;
        end
      end
      msr_pkg::CMD_LOAD: begin
        chan_o.low  = item_i.low_limit_in;
        chan_o.high = item_i.high_limit_in;
        chan_o.pos  = item_i.low_limit_in;
      end
      default: begin
        chan_o = chan_i;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/multi_servo_slew_ramp_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_servo_slew_ramp_top: eight-channel servo slew-rate limiter
// Ramps each channel's position toward its selected endpoint, one unit per
// step period, and attaches or detaches the pulse drive.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Carries
// s_axis    in         command item: tuser = cmd, tdata = channel .. now_ms
// m_axis    out        one result per item: channel, position, moved, drive
// cfg       in         step period (index 0) and hold time (index 1)
//
// Every item passes from its transfer on s_axis into the input register;
// from there the channel update is computed and written to the result
// register and the channel state at once, and the result goes out on m_axis.
// A new item is taken in every cycle as long as m_axis keeps taking results.
// Reset restores all channel state, the round-robin pointer and both
// configuration registers. When m_axis stalls, the input register still
// takes one more item, then s_axis_tready drops.
//
module multi_servo_slew_ramp_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave stream: tdata fields from bit 0: channel[2:0], direction[3],
  // delta[11:4], low_limit_in[19:12], high_limit_in[27:20], now_ms[43:28].
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
  // Master stream: tdata fields from bit 0: serviced_channel[2:0],
  // position[10:3], moved[11], drive_enable[12].
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int unsigned ChW = msr_pkg::CH_W;

  // Configuration registers.
  logic [7:0]  step_period_q;
  logic [15:0] hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_period_q <= msr_pkg::STEP_RESET;
      hold_q        <= msr_pkg::HOLD_RESET;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == msr_pkg::CFG_STEP_PERIOD) begin
        step_period_q <= cfg_wdata_i[7:0];
      end else begin
        hold_q <= cfg_wdata_i;
      end
    end
  end

  // Handshake control. The input register moves on whenever the result
  // register is empty or its content is being taken in this cycle.
  logic           in_valid_q;
  msr_pkg::item_t in_q;
  logic           out_valid_q;
  logic [15:0]    out_data_q;
  logic           out_free;
  logic           advance;
  logic           s_xfer;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_q.cmd           <= msr_pkg::cmd_e'(s_axis_tuser);
      in_q.channel       <= s_axis_tdata[2:0];
      in_q.direction     <= s_axis_tdata[3];
      in_q.delta         <= s_axis_tdata[11:4];
      in_q.low_limit_in  <= s_axis_tdata[19:12];
      in_q.high_limit_in <= s_axis_tdata[27:20];
      in_q.now_ms        <= s_axis_tdata[43:28];
    end
  end

  // Channel state, round-robin pointer and the channel whose direction was
  // set last.
  msr_pkg::chan_t chan_q [msr_pkg::CHANNELS];
  logic [ChW-1:0] rr_q;
  logic [ChW-1:0] rr_d;
  logic [ChW-1:0] last_set_q;
  logic [ChW-1:0] sel;

  always_comb begin
    unique case (in_q.cmd)
      msr_pkg::CMD_TICK:   sel = rr_q;
      msr_pkg::CMD_ADJUST: sel = last_set_q;
      default:             sel = in_q.channel;
    endcase
  end

  assign rr_d = (rr_q == ChW'(msr_pkg::CHANNELS - 1)) ? '0 : rr_q + 1'b1;

  msr_pkg::chan_t chan_cur;
  msr_pkg::chan_t chan_d;
  logic           moved;

  assign chan_cur = chan_q[sel];

  msr_step u_step (
    .item_i        (in_q),
    .chan_i        (chan_cur),
    .step_period_i (step_period_q),
    .hold_i        (hold_q),
    .chan_o        (chan_d),
    .moved_o       (moved)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < msr_pkg::CHANNELS; i++) begin
        chan_q[i] <= '{pos:       msr_pkg::POS_RESET,
                       prev_pos:  8'd0,
                       last_step: 16'd0,
                       last_move: 16'd0,
                       dir:       1'b0,
                       attached:  1'b0,
                       low:       msr_pkg::LOW_RESET,
                       high:      msr_pkg::HIGH_RESET};
      end
      rr_q       <= '0;
      last_set_q <= '0;
    end else if (advance) begin
      chan_q[sel] <= chan_d;
      if (in_q.cmd == msr_pkg::CMD_TICK) begin
        rr_q <= rr_d;
      end
      if (in_q.cmd == msr_pkg::CMD_SET_DIR) begin
        last_set_q <= in_q.channel;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {3'd0, chan_d.attached, moved, chan_d.pos, sel};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire

@@ hdl/msr_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msr_checker: port-level checks of the multi-servo slew ramp
// Watches the stream ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module msr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // A stalled result stays in place unchanged.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A move always attaches the drive.
  a_moved_attached : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[11] |-> m_axis_tdata[12])
    else $error("moved without drive enabled");

  // A downstream side that takes results never blocks the input.
  a_no_block : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input blocked while output drains");

  // No result is shown right after reset.
  a_reset_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid out of reset");

endmodule

bind multi_servo_slew_ramp_top msr_checker u_msr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

@@ test/tb_multi_servo_slew_ramp_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_servo_slew_ramp_top: self-checking bench for the servo slew ramp
// Drives command items into the slave stream and predicts every result
// in-bench. The run starts with a short list of hand-picked commands and
// then moves through several step-period and hold-time settings with
// random command mixes. Results on the master stream are compared field by
// field against the oldest prediction. Both stream sides stall at random,
// and once the result side holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_multi_servo_slew_ramp_top;

  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 205;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int CYCLE_LIMIT     = 200000;

  // Fields of one result, first field in the highest bits.
  typedef struct packed {
    logic [2:0] ch;
    logic [7:0] pos;
    logic       moved;
    logic       drive;
  } res_t;

  // One row of the hand-picked commands. When typed is set, res holds the
  // result read straight off the behavior; otherwise the prediction is used.
  typedef struct packed {
    msr_pkg::item_t it;
    logic           typed;
    res_t           res;
  } row_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;   // channel, direction, delta, low, high, now_ms
  logic [1:0]  s_axis_tuser  = '0;   // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // serviced_channel, position, moved, drive_enable
  logic        cfg_we_i      = 1'b0;
  logic        cfg_addr_i    = 1'b0;
  logic [15:0] cfg_wdata_i   = '0;

  multi_servo_slew_ramp_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Predicted copy of the servo channels and the configuration.
  msr_pkg::chan_t chan_st [msr_pkg::CHANNELS];
  logic [2:0]     rr_ptr;
  logic [2:0]     last_set_ch;
  logic [7:0]     cfg_step;
  logic [15:0]    cfg_hold;

  res_t pending_results [$];
  int   mismatch_cnt = 0;
  int   cycle_cnt    = 0;
  bit   tx_idle_en   = 1'b1;
  bit   rx_idle_en   = 1'b1;
  int   hold_req     = 0;

  // Hand-picked commands, run with the reset configuration (step 20 ms,
  // hold 300 ms). They cover field extremes, every command and the corner
  // cases: a tick that is not yet due, endpoint wrap through the delta, a
  // load of equal limits that reports a move on its first due tick, crossed
  // limits, time wrap-around, and a detach after the hold time.
  row_t directed_tab [23] = '{
    '{'{msr_pkg::CMD_TICK,    3'd0, 1'b0, 8'h00, 8'd0,   8'd0,   16'd0},     1'b1,
      '{3'd0, 8'd45,  1'b0, 1'b0}},
    '{'{msr_pkg::CMD_TICK,    3'd0, 1'b0, 8'h00, 8'd0,   8'd0,   16'd20},    1'b1,
      '{3'd1, 8'd46,  1'b1, 1'b1}},
    '{'{msr_pkg::CMD_SET_DIR, 3'd7, 1'b1, 8'h00, 8'd0,   8'd0,   16'd0},     1'b1,
      '{3'd7, 8'd45,  1'b0, 1'b0}},
    '{'{msr_pkg::CMD_ADJUST,  3'd0, 1'b0, 8'h80, 8'd0,   8'd0,   16'd0},     1'b1,
      '{3'd7, 8'd45,  1'b0, 1'b0}},
    '{'{msr_pkg::CMD_ADJUST,  3'd0, 1'b0, 8'h7f, 8'd0,   8'd0,   16'd0},     1'b1,
      '{3'd7, 8'd45,  1'b0, 1'b0}},
    '{'{msr_pkg::CMD_LOAD,    3'd3, 1'b0, 8'h00, 8'd0,   8'd255, 16'd0},     1'b1,
      '{3'd3, 8'd0,   1'b0, 1'b0}},
    '{'{msr_pkg::CMD_LOAD,    3'd4, 1'b0, 8'h00, 8'd255, 8'd0,   16'd0},     1'b1,
      '{3'd4, 8'd255, 1'b0, 1'b0}},
    '{'{msr_pkg::CMD_LOAD,    3'd5, 1'b0, 8'h00, 8'd100, 8'd100, 16'd0},     1'b1,
      '{3'd5, 8'd100, 1'b0, 1'b0}},
    '{'{msr_pkg::CMD_SET_DIR, 3'd0, 1'b1, 8'h00, 8'd0,   8'd0,   16'd0},     1'b1,
      '{3'd0, 8'd45,  1'b0, 1'b0}},
    '{'{msr_pkg::CMD_TICK,    3'd0, 1'b0, 8'h00, 8'd0,   8'd0,   16'hffff},  1'b0, '0},
    '{'{msr_pkg::CMD_TICK,    3'd0, 1'b0, 8'h00, 8'd0,   8'd0,   16'hffff},  1'b0, '0},
    '{'{msr_pkg::CMD_TICK,    3'd0, 1'b0, 8'h00, 8'd0,   8'd0,   16'd0},     1'b1,
      '{3'd4, 8'd255, 1'b0, 1'b0}},
    '{'{msr_pkg::CMD_TICK,    3'd0, 1'b0, 8'h00, 8'd0,   8'd0,   16'd40},    1'b0, '0},
    '{'{msr_pkg::CMD_TICK,    3'd0, 1'b0, 8'h00, 8'd0,   8'd0,   16'd40},    1'b0, '0},
    '{'{msr_pkg::CMD_TICK,    3'd0, 1'b0, 8'h00, 8'd0,   8'd0,   16'd40},    1'b0, '0},
    '{'{msr_pkg::CMD_TICK,    3'd0, 1'b0, 8'h00, 8'd0,   8'd0,   16'd400},   1'b0, '0},
    '{'{msr_pkg::CMD_TICK,    3'd0, 1'b0, 8'h00, 8'd0,   8'd0,   16'd400},   1'b0, '0},
    '{'{msr_pkg::CMD_TICK,    3'd0, 1'b0, 8'h00, 8'd0,   8'd0,   16'd400},   1'b0, '0},
    '{'{msr_pkg::CMD_TICK,    3'd0, 1'b0, 8'h00, 8'd0,   8'd0,   16'd400},   1'b0, '0},
    '{'{msr_pkg::CMD_TICK,    3'd0, 1'b0, 8'h00, 8'd0,   8'd0,   16'd400},   1'b0, '0},
    '{'{msr_pkg::CMD_TICK,    3'd0, 1'b0, 8'h00, 8'd0,   8'd0,   16'd400},   1'b0, '0},
    '{'{msr_pkg::CMD_SET_DIR, 3'd6, 1'b0, 8'h00, 8'd0,   8'd0,   16'd0},     1'b0, '0},
    '{'{msr_pkg::CMD_ADJUST,  3'd0, 1'b0, 8'h05, 8'd0,   8'd0,   16'd0},     1'b0, '0}
  };

  localparam logic [7:0]  STEP_SET [NUM_PHASES-1] = '{8'd0, 8'd255, 8'd1, 8'd5, 8'd20};
  localparam logic [15:0] HOLD_SET [NUM_PHASES-1] =
    '{16'd0, 16'hffff, 16'd20, 16'd100, 16'd300};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Applies one accepted command to the predicted channel state and returns
  // the result it causes.
  function automatic res_t servo_step(msr_pkg::item_t it);
    res_t       r;
    logic [2:0] ch;
    logic [7:0] goal;
    r  = '0;
    ch = it.channel;
    case (it.cmd)
      msr_pkg::CMD_TICK: begin
        ch = rr_ptr;
        if (16'(it.now_ms - chan_st[ch].last_step) >= {8'd0, cfg_step}) begin
          chan_st[ch].last_step = it.now_ms;
          goal = chan_st[ch].dir ? chan_st[ch].low : chan_st[ch].high;
          if (chan_st[ch].pos < goal) begin
            chan_st[ch].pos = chan_st[ch].pos + 8'd1;
          end else if (chan_st[ch].pos > goal) begin
            chan_st[ch].pos = chan_st[ch].pos - 8'd1;
          end
          if (chan_st[ch].pos != chan_st[ch].prev_pos) begin
            chan_st[ch].prev_pos  = chan_st[ch].pos;
            chan_st[ch].attached  = 1'b1;
            chan_st[ch].last_move = it.now_ms;
            r.moved = 1'b1;
          end
          // Detach only once parked at an endpoint and the hold has run out.
          if ((chan_st[ch].pos == chan_st[ch].high || chan_st[ch].pos == chan_st[ch].low) &&
              16'(it.now_ms - chan_st[ch].last_move) > cfg_hold) begin
            chan_st[ch].attached = 1'b0;
          end
        end
        rr_ptr = rr_ptr + 3'd1;
      end
      msr_pkg::CMD_SET_DIR: begin
        last_set_ch = ch;
        chan_st[ch].dir = it.direction;
      end
      msr_pkg::CMD_ADJUST: begin
        ch = last_set_ch;
        if (chan_st[ch].dir == 1'b0) begin
          chan_st[ch].high = chan_st[ch].high + it.delta;
        end else begin
          chan_st[ch].low = chan_st[ch].low + it.delta;
        end
      end
      default: begin
        chan_st[ch].low  = it.low_limit_in;
        chan_st[ch].high = it.high_limit_in;
        chan_st[ch].pos  = it.low_limit_in;
      end
    endcase
    r.ch    = ch;
    r.pos   = chan_st[ch].pos;
    r.drive = chan_st[ch].attached;
    return r;
  endfunction

  // Offers one command until it is taken, then records its predicted result.
  // A random gap may follow the transfer.
  task automatic offer_command(input msr_pkg::item_t it, input logic typed,
                               input res_t typed_res);
    res_t predicted;
    s_axis_tdata  <= {4'd0, it.now_ms, it.high_limit_in, it.low_limit_in, it.delta,
                      it.direction, it.channel};
    s_axis_tuser  <= it.cmd;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = servo_step(it);
    pending_results.push_back(typed ? typed_res : predicted);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Result side: checks each transfer, then picks the next tready. A long
  // hold-off is served whenever the stimulus side raises a new request.
  initial begin
    int   stall_left;
    int   hold_done;
    res_t got;
    res_t want;
    stall_left = 0;
    hold_done  = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[2:0], m_axis_tdata[10:3], m_axis_tdata[11], m_axis_tdata[12]};
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %p", $time, got);
          mismatch_cnt++;
        end else begin
          want = pending_results.pop_front();
          if (got.ch != want.ch) begin
            $display("%0t: serviced_channel expected %0d actual %0d", $time, want.ch, got.ch);
            mismatch_cnt++;
          end
          if (got.pos != want.pos) begin
            $display("%0t: position expected %0d actual %0d", $time, want.pos, got.pos);
            mismatch_cnt++;
          end
          if (got.moved != want.moved) begin
            $display("%0t: moved expected %0d actual %0d", $time, want.moved, got.moved);
            mismatch_cnt++;
          end
          if (got.drive != want.drive) begin
            $display("%0t: drive_enable expected %0d actual %0d", $time, want.drive,
                     got.drive);
            mismatch_cnt++;
          end
        end
      end
      if (hold_req != hold_done) begin
        stall_left = HOLD_OFF_CYCLES;
        hold_done  = hold_req;
      end else if (stall_left == 0 && rx_idle_en && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 6);
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Stimulus: reset, hand-picked commands, then one random phase per setting.
  initial begin
    msr_pkg::item_t it;
    logic [15:0]    clock_ms;
    logic [7:0]     new_step;
    logic [15:0]    new_hold;
    int             r;
    for (int c = 0; c < msr_pkg::CHANNELS; c++) begin
      chan_st[c] = '{pos:       msr_pkg::POS_RESET,
                     prev_pos:  8'd0,
                     last_step: 16'd0,
                     last_move: 16'd0,
                     dir:       1'b0,
                     attached:  1'b0,
                     low:       msr_pkg::LOW_RESET,
                     high:      msr_pkg::HIGH_RESET};
    end
    rr_ptr      = '0;
    last_set_ch = '0;
    cfg_step    = msr_pkg::STEP_RESET;
    cfg_hold    = msr_pkg::HOLD_RESET;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_tab[k]) begin
      offer_command(directed_tab[k].it, directed_tab[k].typed, directed_tab[k].res);
    end
    s_axis_tvalid <= 1'b0;
    clock_ms = 16'd400;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // Registers change only with the block drained.
      while (pending_results.size() != 0) @(posedge clk_i);
      repeat (4) @(posedge clk_i);
      if (ph < NUM_PHASES - 1) begin
        new_step = STEP_SET[ph];
        new_hold = HOLD_SET[ph];
      end else begin
        // Last stretch: random setting and no idling on either side.
        new_step   = 8'($urandom_range(0, 40));
        new_hold   = 16'($urandom_range(0, 400));
        tx_idle_en = 1'b0;
        rx_idle_en <= 1'b0;
      end
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= msr_pkg::CFG_STEP_PERIOD;
      cfg_wdata_i <= {8'd0, new_step};
      @(posedge clk_i);
      cfg_addr_i  <= msr_pkg::CFG_HOLD;
      cfg_wdata_i <= new_hold;
      @(posedge clk_i);
      cfg_we_i    <= 1'b0;
      cfg_step = new_step;
      cfg_hold = new_hold;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Mostly ticks on a steadily advancing clock, so channels ramp into
        // their endpoints and sit out the hold time; narrow limit loads keep
        // the ramps short.
        r = $urandom_range(0, 99);
        if (r < 70) begin
          it.cmd = msr_pkg::CMD_TICK;
        end else if (r < 80) begin
          it.cmd = msr_pkg::CMD_SET_DIR;
        end else if (r < 88) begin
          it.cmd = msr_pkg::CMD_ADJUST;
        end else begin
          it.cmd = msr_pkg::CMD_LOAD;
        end
        it.channel   = 3'($urandom);
        it.direction = 1'($urandom);
        it.delta     = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 8) - 4)
                                                   : 8'($urandom);
        it.low_limit_in  = 8'($urandom);
        it.high_limit_in = ($urandom_range(0, 4) != 0)
                         ? 8'(it.low_limit_in + $urandom_range(0, 12) - 6) : 8'($urandom);
        clock_ms  = clock_ms + 16'($urandom_range(0, cfg_step / 4 + 6));
        it.now_ms = ($urandom_range(0, 24) == 0) ? 16'($urandom) : clock_ms;
        offer_command(it, 1'b0, '0);

        if (n == ITEMS_PER_PHASE / 2) begin
          if (ph == 2) begin
            // Result side holds off while commands keep coming.
            hold_req <= hold_req + 1;
          end else if (ph == 3) begin
            // The sender goes quiet until all results are in.
            s_axis_tvalid <= 1'b0;
            do @(posedge clk_i); while (pending_results.size() != 0);
          end
        end
      end
      s_axis_tvalid <= 1'b0;
    end

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
